@@ src/lcpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcpm_pkg: shared types and constants of the load-cell mass block
// Request payloads, lane results and the fixed calibration constants.
// ----------------------------------------------------------------------------
`default_nettype none
package lcpm_pkg;

  localparam int LANES    = 4;
  localparam int RAW_W    = 16;
  localparam int CAL_W    = 48;
  localparam int NUM_W    = 31;   // 17000 * 65535 fits in 31 bits
  localparam int KG_W     = 7;    // per-lane kilograms, at most 65
  localparam int TOTAL_W  = 9;
  localparam int IDX_W    = 3;

  localparam logic [RAW_W-1:0] SEGMENT_GRAMS   = 16'd17000;
  localparam logic [RAW_W-1:0] TOP_POINT_GRAMS = 16'd34000;
  localparam logic [RAW_W-1:0] GRAMS_MAX       = 16'hFFFF;
  // floor(g / 1000) == (g * 134218) >> 27 for every 16-bit g
  localparam logic [17:0]      KG_RECIP        = 18'd134218;
  localparam int               KG_SHIFT        = 27;

  typedef logic [IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_CAL_SENSOR_0 = 3'd0;
  localparam cfg_index_t REG_CAL_SENSOR_1 = 3'd1;
  localparam cfg_index_t REG_CAL_SENSOR_2 = 3'd2;
  localparam cfg_index_t REG_CAL_SENSOR_3 = 3'd3;

  typedef struct packed {
    logic [RAW_W-1:0] raw_front_right;
    logic [RAW_W-1:0] raw_back_right;
    logic [RAW_W-1:0] raw_front_left;
    logic [RAW_W-1:0] raw_back_left;
  } in_t;

  typedef struct packed {
    logic [RAW_W-1:0]   grams_front_right;
    logic [RAW_W-1:0]   grams_back_right;
    logic [RAW_W-1:0]   grams_front_left;
    logic [RAW_W-1:0]   grams_back_left;
    logic [TOTAL_W-1:0] total_kilograms;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [RAW_W-1:0] grams;
    logic [KG_W-1:0]  kg;
    logic             sat;
  } lane_res_t;

endpackage
`default_nettype wire

@@ src/lcpm_lane.sv @@
// ----------------------------------------------------------------------------
// lcpm_lane: one sensor lane
// Segment select, scale by 17000, pipelined restoring divide, saturate, kg.
// ----------------------------------------------------------------------------
`default_nettype none
module lcpm_lane (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [lcpm_pkg::CAL_W-1:0] cal,
  input  wire logic [lcpm_pkg::RAW_W-1:0] raw,
  output lcpm_pkg::lane_res_t           res
);
  import lcpm_pkg::*;

  logic [RAW_W-1:0] c0, c1, c2;
  logic [RAW_W-1:0] diff_c, div_c, base_c;
  logic             fs_c;

  assign c0 = cal[15:0];
  assign c1 = cal[31:16];
  assign c2 = cal[47:32];

  // pick segment in the order of the comparisons
  always_comb begin
    diff_c = '0;
    div_c  = 16'd1;
    base_c = '0;
    fs_c   = 1'b0;
    if (raw < c0) begin
      diff_c = '0;
    end else if (raw < c1) begin
      diff_c = raw - c0;
      div_c  = c1 - c0;
    end else if (raw < c2) begin
      diff_c = raw - c1;
      div_c  = c2 - c1;
      base_c = SEGMENT_GRAMS;
    end else if (c2 <= c1) begin
      fs_c   = 1'b1;
    end else begin
      diff_c = raw - c2;
      div_c  = c2 - c1;
      base_c = TOP_POINT_GRAMS;
    end
  end

  logic [RAW_W-1:0] s0_diff, s0_div, s0_base;
  logic             s0_fs;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_diff <= diff_c;
      s0_div  <= div_c;
      s0_base <= base_c;
      s0_fs   <= fs_c;
    end
  end

  logic [NUM_W-1:0] num_q  [0:NUM_W];
  logic [NUM_W-1:0] quo_q  [0:NUM_W];
  logic [RAW_W-1:0] rem_q  [0:NUM_W];
  logic [RAW_W-1:0] div_q  [0:NUM_W];
  logic [RAW_W-1:0] base_q [0:NUM_W];
  logic             fs_q   [0:NUM_W];

  always_ff @(posedge clk) begin
    if (en) begin
      num_q[0]  <= NUM_W'(32'(s0_diff) * 32'(SEGMENT_GRAMS));
      quo_q[0]  <= '0;
      rem_q[0]  <= '0;
      div_q[0]  <= s0_div;
      base_q[0] <= s0_base;
      fs_q[0]   <= s0_fs;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [RAW_W:0]   trial;
    logic             ge;
    logic [RAW_W-1:0] rem_next;

    assign trial    = {rem_q[k], num_q[k][NUM_W-1]};
    assign ge       = trial >= {1'b0, div_q[k]};
    assign rem_next = ge ? RAW_W'(trial - {1'b0, div_q[k]}) : trial[RAW_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[k+1]  <= {num_q[k][NUM_W-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][NUM_W-2:0], ge};
        rem_q[k+1]  <= rem_next;
        div_q[k+1]  <= div_q[k];
        base_q[k+1] <= base_q[k];
        fs_q[k+1]   <= fs_q[k];
      end
    end
  end

  logic [31:0]      sum_c;
  logic [RAW_W-1:0] f1_grams;
  logic             f1_sat;

  assign sum_c = 32'(base_q[NUM_W]) + 32'(quo_q[NUM_W]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (fs_q[NUM_W] || sum_c > 32'(GRAMS_MAX)) begin
        f1_grams <= GRAMS_MAX;
        f1_sat   <= 1'b1;
      end else begin
        f1_grams <= sum_c[RAW_W-1:0];
        f1_sat   <= 1'b0;
      end
    end
  end

  logic [33:0] kg_prod;
  assign kg_prod = 34'(f1_grams) * 34'(KG_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      res.grams <= f1_grams;
      res.sat   <= f1_sat;
      res.kg    <= KG_W'(kg_prod >> KG_SHIFT);
    end
  end

endmodule
`default_nettype wire

@@ src/lcpm_merge.sv @@
// ----------------------------------------------------------------------------
// lcpm_merge: combine the four lanes
// Sum kilograms, gather saturation flags, register the result payload.
// ----------------------------------------------------------------------------
`default_nettype none
module lcpm_merge (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire lcpm_pkg::lane_res_t lane [lcpm_pkg::LANES],
  output lcpm_pkg::out_t           data
);
  import lcpm_pkg::*;

  logic [TOTAL_W-1:0] total_c;

  assign total_c = TOTAL_W'(lane[0].kg) + TOTAL_W'(lane[1].kg)
                 + TOTAL_W'(lane[2].kg) + TOTAL_W'(lane[3].kg);

  always_ff @(posedge clk) begin
    if (en) begin
      data.grams_front_right <= lane[0].grams;
      data.grams_back_right  <= lane[1].grams;
      data.grams_front_left  <= lane[2].grams;
      data.grams_back_left   <= lane[3].grams;
      data.total_kilograms   <= total_c;
      data.saturated         <= lane[0].sat | lane[1].sat | lane[2].sat | lane[3].sat;
    end
  end

endmodule
`default_nettype wire

@@ src/load_cell_piecewise_mass_top.sv @@
// ----------------------------------------------------------------------------
// load_cell_piecewise_mass_top: four-sensor load-cell mass converter
// Converts raw readings to grams by three-point piecewise calibration.
// ----------------------------------------------------------------------------
// One request per clock is taken while the output side keeps up. Each request
// goes through four identical lanes side by side and then a merging stage; a
// new request can enter before earlier ones are through, one per cycle while
// the output is not stalled. The pipeline depth is set by the restoring divider
// in each lane, which yields one quotient bit per stage over 31 stages, plus
// segment select, scaling, saturation, kilogram and merge stages. The whole
// pipeline advances together: when the output register holds a result that is
// not taken, every stage holds and in_ready drops. Calibration registers are
// written through cfg_we/cfg_index/cfg_data; indexes above 3 are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module load_cell_piecewise_mass_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire lcpm_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output lcpm_pkg::out_t                  out_data,
  input  wire logic                       cfg_we,
  input  wire logic [lcpm_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [lcpm_pkg::CAL_W-1:0] cfg_data
);
  import lcpm_pkg::*;

  // segment, scale, divider, saturate, kilogram stages inside each lane
  localparam int PIPE_D = NUM_W + 4;

  logic [CAL_W-1:0] cal [LANES];
  logic [RAW_W-1:0] raw [LANES];
  lane_res_t        lane_res [LANES];
  logic [PIPE_D-1:0] vld;
  logic             en;

  // advance everything unless a finished result is still waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) cal[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_SENSOR_0: cal[0] <= cfg_data;
        REG_CAL_SENSOR_1: cal[1] <= cfg_data;
        REG_CAL_SENSOR_2: cal[2] <= cfg_data;
        REG_CAL_SENSOR_3: cal[3] <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign raw[0] = in_data.raw_front_right;
  assign raw[1] = in_data.raw_back_right;
  assign raw[2] = in_data.raw_front_left;
  assign raw[3] = in_data.raw_back_left;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lcpm_lane u_lane (
      .clk (clk),
      .en  (en),
      .cal (cal[l]),
      .raw (raw[l]),
      .res (lane_res[l])
    );
  end

  lcpm_merge u_merge (
    .clk  (clk),
    .en   (en),
    .lane (lane_res),
    .data (out_data)
  );

  // track which stages hold a live request
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[PIPE_D-2:0], in_valid};
      out_valid <= vld[PIPE_D-1];
    end
  end

endmodule
`default_nettype wire

@@ src/lcpm_checker.sv @@
// ----------------------------------------------------------------------------
// lcpm_checker: port-level checks of the load-cell mass block
// Watches handshakes and result payloads at the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module lcpm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire lcpm_pkg::out_t out_data
);
  import lcpm_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("request side not tied to output stall");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      out_data.grams_front_right == GRAMS_MAX || out_data.grams_back_right == GRAMS_MAX ||
      out_data.grams_front_left == GRAMS_MAX || out_data.grams_back_left == GRAMS_MAX)
    else $error("saturation flag without a saturated lane");

  a_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.total_kilograms <= 9'd260)
    else $error("kilogram total out of range");

endmodule

bind load_cell_piecewise_mass_top lcpm_checker u_lcpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ bench/load_cell_piecewise_mass_top_tb.sv @@
// ----------------------------------------------------------------------------
// load_cell_piecewise_mass_top_tb: self-checking bench of the load-cell block
// Drives sensor reports under several calibration sets and random idling,
// predicts grams, kilograms and saturation per report and checks each result.
// ----------------------------------------------------------------------------
`default_nettype none
module load_cell_piecewise_mass_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcpm_pkg::*;

  localparam int LATENCY = 36;
  // an index past the register list, written to check it is dropped
  localparam cfg_index_t REG_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = '0;
  logic [CAL_W-1:0] cfg_data = '0;

  // Pending requests for the driver and the expected results in order
  in_t pending_reqs[$];
  out_t expected_mass[$];
  logic [CAL_W-1:0] cal_copy[LANES];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  bit hold_send = 1'b0;

  load_cell_piecewise_mass_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Grams on one lane: zero below the first point, interpolate between the
  // points, extrapolate with the upper slope and saturate at 16 bits.
  function automatic logic [RAW_W-1:0] lane_mass(input logic [CAL_W-1:0] cal,
                                                 input logic [RAW_W-1:0] r,
                                                 inout bit sat);
    longint unsigned c0, c1, c2, v;
    c0 = cal[15:0];
    c1 = cal[31:16];
    c2 = cal[47:32];
    if (r < c0) return '0;
    if (r < c1) return RAW_W'((17000 * (r - c0)) / (c1 - c0));
    if (r < c2) return RAW_W'(17000 + (17000 * (r - c1)) / (c2 - c1));
    // flat or falling upper segment has no usable slope
    if (c2 <= c1) begin
      sat = 1'b1;
      return GRAMS_MAX;
    end
    v = 34000 + (17000 * (r - c2)) / (c2 - c1);
    if (v > 65535) begin
      sat = 1'b1;
      return GRAMS_MAX;
    end
    return v[15:0];
  endfunction

  function automatic out_t report_mass(input in_t req);
    out_t res;
    bit sat;
    int total;
    sat = 1'b0;
    res.grams_front_right = lane_mass(cal_copy[0], req.raw_front_right, sat);
    res.grams_back_right  = lane_mass(cal_copy[1], req.raw_back_right, sat);
    res.grams_front_left  = lane_mass(cal_copy[2], req.raw_front_left, sat);
    res.grams_back_left   = lane_mass(cal_copy[3], req.raw_back_left, sat);
    total = res.grams_front_right / 1000 + res.grams_back_right / 1000 +
            res.grams_front_left / 1000 + res.grams_back_left / 1000;
    res.total_kilograms = total[TOTAL_W-1:0];
    res.saturated = sat;
    return res;
  endfunction

  // Driver: present a request whenever one is queued and the idle draw allows;
  // hold it steady until accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_mass.push_back(report_mass(in_data));
        void'(pending_reqs.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: randomly stall, compare each accepted result with the oldest
  // expectation.
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_mass.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_res = expected_mass.pop_front();
          if (out_data !== exp_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_res, out_data);
          end
        end
      end
    end
  end

  task automatic write_cal(input cfg_index_t idx, input logic [CAL_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < LANES) cal_copy[idx[1:0]] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued request has gone and every result has come back.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_mass.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [CAL_W-1:0] pack_cal(input int c0, input int c1, input int c2);
    return {c2[15:0], c1[15:0], c0[15:0]};
  endfunction

  function automatic logic [RAW_W-1:0] raw_near(input logic [CAL_W-1:0] cal);
    int pt;
    int r;
    case ($urandom_range(5))
      0: return RAW_W'($urandom);
      1: pt = int'(cal[15:0]);
      2: pt = int'(cal[31:16]);
      default: pt = int'(cal[47:32]);
    endcase
    r = pt + $signed($urandom_range(400)) - 200;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  task automatic queue_random(input int n);
    in_t req;
    repeat (n) begin
      req.raw_front_right = raw_near(cal_copy[0]);
      req.raw_back_right  = raw_near(cal_copy[1]);
      req.raw_front_left  = raw_near(cal_copy[2]);
      req.raw_back_left   = raw_near(cal_copy[3]);
      pending_reqs.push_back(req);
    end
  endtask

  task automatic random_cal();
    int c0, c1, c2;
    for (int i = 0; i < LANES; i++) begin
      c0 = $urandom_range(20000);
      c1 = c0 + $urandom_range(1, 20000);
      c2 = c1 + $urandom_range(1, 20000);
      // now and then leave the calibration unordered or flat
      if ($urandom_range(7) == 0) c2 = c1 - $urandom_range(1000);
      if ($urandom_range(7) == 0) c2 = $urandom_range(1, 3) + c1;
      write_cal(cfg_index_t'(i), pack_cal(c0, c1, c2));
    end
  endtask

  initial begin
    for (int i = 0; i < LANES; i++) cal_copy[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed: reset calibration (all flat) then a set of typical and edge-case points
    pending_reqs.push_back('{16'h0000, 16'hFFFF, 16'h0001, 16'h8000});
    drain();
    write_cal(REG_CAL_SENSOR_0, pack_cal(1000, 5000, 9000));
    write_cal(REG_CAL_SENSOR_1, pack_cal(0, 1, 2));
    write_cal(REG_CAL_SENSOR_2, pack_cal(100, 30000, 20000));
    write_cal(REG_CAL_SENSOR_3, {16'hFFFF, 16'hFFFE, 16'h0000});
    write_cal(REG_UNUSED, {CAL_W{1'b1}});
    pending_reqs.push_back('{16'd999, 16'd0, 16'd99, 16'd0});
    pending_reqs.push_back('{16'd1000, 16'd1, 16'd100, 16'hFFFE});
    pending_reqs.push_back('{16'd4999, 16'd2, 16'd29999, 16'hFFFF});
    pending_reqs.push_back('{16'd5000, 16'hFFFF, 16'd30000, 16'h7FFF});
    pending_reqs.push_back('{16'd8999, 16'd3, 16'hFFFF, 16'h0001});
    pending_reqs.push_back('{16'd9000, 16'h5555, 16'hAAAA, 16'hAAAA});
    pending_reqs.push_back('{16'hFFFF, 16'hAAAA, 16'h5555, 16'h5555});
    pending_reqs.push_back('{16'd12000, 16'd100, 16'd25000, 16'd40000});
    drain();
    // random phases over several calibration sets and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 28; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 5)
        for (int i = 0; i < LANES; i++)
          write_cal(cfg_index_t'(i), {CAL_W{1'b1}});
      else
        random_cal();
      queue_random(50);
      // let everything come back before sending more
      while (pending_reqs.size() > 25) @(posedge clk);
      hold_send = 1'b1;
      while (in_valid || expected_mass.size() != 0) @(posedge clk);
      hold_send = 1'b0;
      queue_random(50);
      drain();
    end
    if (mismatches == 0)
      $display("PASS load_cell_piecewise_mass_top");
    else
      $display("FAIL load_cell_piecewise_mass_top");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL load_cell_piecewise_mass_top");
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/lcpm_pkg.sv
src/lcpm_lane.sv
src/lcpm_merge.sv
src/load_cell_piecewise_mass_top.sv
src/lcpm_checker.sv
bench/load_cell_piecewise_mass_top_tb.sv
